/* hdl/dsu_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the union-find engine.
// Used by dsu_ctrl, dsu_datapath and the top level; depends on nothing.
package dsu_pkg;

  localparam int ELEM_W    = 10;
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 8;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clr_step;   // write entry clr = clr, advance clr
    logic load_req;   // capture request, start find of first element
    logic rd_cur;     // read parent of cur
    logic walk_step;  // cur <= parent just read, read its parent
    logic set_root;   // root <= cur, cur <= node
    logic cmp_wr;     // parent[cur] <= root, cur <= old parent
    logic start_b;    // ra <= root, start find of second element
    logic union_wr;   // parent[ra] <= root
    logic out_load;   // load result register
  } dsu_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic in_range_in;
    logic rd_is_self;
    logic cur_is_root;
    logic second_find;
    logic union_needed;
    logic out_free;
  } dsu_stat_t;

endpackage

/* hdl/dsu_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine of the union-find engine.
// Depends on dsu_pkg; drives dsu_datapath through dsu_cmd_t.
module dsu_ctrl
  import dsu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  dsu_stat_t stat,
  output dsu_cmd_t  cmd
);

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_WALK_RD  = 3'd2;
  localparam logic [2:0] ST_WALK_CHK = 3'd3;
  localparam logic [2:0] ST_CMP_RD   = 3'd4;
  localparam logic [2:0] ST_CMP_WR   = 3'd5;
  localparam logic [2:0] ST_UNION    = 3'd6;
  localparam logic [2:0] ST_DONE     = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_req = 1'b1;
          state_next   = stat.in_range_in ? ST_WALK_RD : ST_DONE;
        end
      end
      ST_WALK_RD: begin
        cmd.rd_cur = 1'b1;
        state_next = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        if (stat.rd_is_self) begin
          cmd.set_root = 1'b1;
          state_next   = ST_CMP_RD;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      ST_CMP_RD: begin
        if (stat.cur_is_root) begin
          if (!stat.second_find) begin
            cmd.start_b = 1'b1;
            state_next  = ST_WALK_RD;
          end else begin
            state_next = stat.union_needed ? ST_UNION : ST_DONE;
          end
        end else begin
          cmd.rd_cur = 1'b1;
          state_next = ST_CMP_WR;
        end
      end
      ST_CMP_WR: begin
        cmd.cmp_wr = 1'b1;
        state_next = ST_CMP_RD;
      end
      ST_UNION: begin
        cmd.union_wr = 1'b1;
        state_next   = ST_DONE;
      end
      ST_DONE: begin
        // hold until the result register is free
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

/* hdl/dsu_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the union-find engine: parent memory, walk registers, result register.
// Depends on dsu_pkg; commanded by dsu_ctrl.
module dsu_datapath
  import dsu_pkg::*;
#(
  parameter int ELEMENTS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  input  dsu_cmd_t             cmd,
  output dsu_stat_t            stat
);

  localparam int IDX_W = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

  logic [IDX_W-1:0] mem [ELEMENTS];
  logic [IDX_W-1:0] rd_data;
  logic [IDX_W-1:0] clr;
  logic [IDX_W-1:0] cur;
  logic [IDX_W-1:0] node;
  logic [IDX_W-1:0] root;
  logic [IDX_W-1:0] ra;
  logic [IDX_W-1:0] elem_b;
  logic             kind;
  logic             in_range;
  logic             second_find;
  logic             same_set;

  logic [ELEM_W-1:0] first_in;
  logic [ELEM_W-1:0] second_in;
  logic              in_range_in;

  logic [IDX_W-1:0] mem_addr;
  logic [IDX_W-1:0] mem_wdata;
  logic             mem_we;

  assign first_in    = s_tdata[ELEM_W-1:0];
  assign second_in   = s_tdata[2*ELEM_W-1:ELEM_W];
  assign in_range_in = (32'(first_in) < ELEMENTS) && (32'(second_in) < ELEMENTS);

  always_comb begin
    mem_addr  = cur;
    mem_wdata = root;
    mem_we    = 1'b0;
    if (cmd.clr_step) begin
      mem_addr  = clr;
      mem_wdata = clr;
      mem_we    = 1'b1;
    end else if (cmd.walk_step) begin
      mem_addr = rd_data;
    end else if (cmd.rd_cur) begin
      mem_addr = cur;
    end else if (cmd.cmp_wr) begin
      mem_we = 1'b1;
    end else if (cmd.union_wr) begin
      mem_addr = ra;
      mem_we   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (cmd.clr_step) begin
      clr <= clr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      kind        <= s_tuser;
      in_range    <= in_range_in;
      cur         <= IDX_W'(first_in);
      node        <= IDX_W'(first_in);
      elem_b      <= IDX_W'(second_in);
      second_find <= 1'b0;
    end else if (cmd.walk_step) begin
      cur <= rd_data;
    end else if (cmd.set_root) begin
      root <= cur;
      cur  <= node;
    end else if (cmd.cmp_wr) begin
      cur <= rd_data;
    end else if (cmd.start_b) begin
      ra          <= root;
      cur         <= elem_b;
      node        <= elem_b;
      second_find <= 1'b1;
    end
  end

  // result register; root holds the second root once both finds are done
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      same_set <= in_range && (ra == root);
    end
  end

  assign m_tdata = {{(M_TDATA_W-1){1'b0}}, same_set};

  assign stat.clr_last     = (clr == IDX_W'(ELEMENTS - 1));
  assign stat.in_range_in  = in_range_in;
  assign stat.rd_is_self   = (rd_data == cur);
  assign stat.cur_is_root  = (cur == root);
  assign stat.second_find  = second_find;
  assign stat.union_needed = !kind && (ra != root);
  assign stat.out_free     = !m_tvalid || m_tready;

endmodule

/* hdl/disjoint_set_union_find.sv */
`timescale 1ns / 1ps
// Union-find engine with full path compression over a single-port parent memory.
// One request at a time: a find walks its path with one read per cycle, then
// rewrites each entry on the path with a read and a write; a request loads,
// runs both finds and writes a union if needed; out-of-range requests skip the finds.
// Reset runs a clearing pass that sets each entry to its own index.
module disjoint_set_union_find
  import dsu_pkg::*;
#(
  parameter int ELEMENTS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // first_element[9:0], second_element[19:10], zero pad
  input  logic                 s_tuser,  // req_type: 0 union, 1 query
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata   // same_set[0], zero pad
);

  dsu_cmd_t  cmd;
  dsu_stat_t stat;

  dsu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dsu_datapath #(
    .ELEMENTS (ELEMENTS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for disjoint_set_union_find: directed requests, then random
// ones, predicted against a parent table with full path compression; needs dsu_pkg.
module tb_top
  import dsu_pkg::*;
();

  localparam int NUM_ELEM    = 1024;
  localparam int RAND_ITEMS  = 1200;
  localparam int HOLD_AT     = 300;     // result count at which the long hold-off starts
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_LIMIT = 200000;
  localparam int TAIL_CYCLES = 64;

  typedef enum logic {
    REQ_UNION = 1'b0,
    REQ_QUERY = 1'b1
  } req_kind_t;

  typedef struct {
    req_kind_t kind;
    int        first;
    int        second;
    bit        known;      // expected value typed in below
    bit        known_same;
  } dir_row_t;

  localparam int DIR_ROWS = 22;

  // Typed expectations only where they are obvious; the rest go to the predictor.
  dir_row_t dir_tab [0:DIR_ROWS-1] = '{
    '{REQ_QUERY,    0, 1023, 1'b1, 1'b0},  // fresh table: separate sets
    '{REQ_QUERY, 1023, 1023, 1'b1, 1'b1},  // same element twice
    '{REQ_QUERY,    0,    0, 1'b1, 1'b1},
    '{REQ_UNION,    0, 1023, 1'b1, 1'b0},
    '{REQ_QUERY, 1023,    0, 1'b1, 1'b1},
    '{REQ_UNION, 1023,    0, 1'b1, 1'b1},  // union of joined sets
    '{REQ_UNION,  682,  341, 1'b1, 1'b0},  // alternating bit patterns
    '{REQ_QUERY,  341,  682, 1'b1, 1'b1},
    '{REQ_UNION,    1,    2, 1'b1, 1'b0},
    '{REQ_UNION,    2,    3, 1'b1, 1'b0},
    '{REQ_UNION,    3,    4, 1'b1, 1'b0},
    '{REQ_QUERY,    1,    4, 1'b1, 1'b1},  // walks and compresses a chain
    '{REQ_UNION,    4,    0, 1'b1, 1'b0},
    '{REQ_QUERY,    1, 1023, 1'b0, 1'b0},
    '{REQ_UNION,  341,    1, 1'b0, 1'b0},
    '{REQ_QUERY,  682,    0, 1'b0, 1'b0},
    '{REQ_UNION,    5,    5, 1'b1, 1'b1},  // union naming one element twice
    '{REQ_QUERY,    5,    6, 1'b1, 1'b0},
    '{REQ_UNION,  512,  511, 1'b0, 1'b0},
    '{REQ_QUERY,  511,    2, 1'b0, 1'b0},
    '{REQ_UNION,    6,  512, 1'b0, 1'b0},
    '{REQ_QUERY,    5, 1022, 1'b0, 1'b0}
  };

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;   // first_element[9:0], second_element[19:10], zero pad
  logic                 s_tuser = 1'b0; // req_type
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;        // same_set[0], zero pad

  logic [ELEM_W-1:0] parent_tbl [0:NUM_ELEM-1];
  bit                same_set_q [$];
  int                n_err = 0;
  int                n_results = 0;
  int                tx_calm = 0;

  disjoint_set_union_find #(.ELEMENTS(NUM_ELEM)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(40_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  // Mostly short gaps, a few long ones.
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Walk to the root, then point every entry on the walked path at it.
  function automatic logic [ELEM_W-1:0] find_compress(input logic [ELEM_W-1:0] node);
    logic [ELEM_W-1:0] root;
    logic [ELEM_W-1:0] cur;
    logic [ELEM_W-1:0] nxt;
    int                steps;
    root  = node;
    steps = 0;
    while (parent_tbl[root] != root && steps < NUM_ELEM) begin
      root = parent_tbl[root];
      steps++;
    end
    cur   = node;
    steps = 0;
    while (cur != root && steps < NUM_ELEM) begin
      nxt             = parent_tbl[cur];
      parent_tbl[cur] = root;
      cur             = nxt;
      steps++;
    end
    return root;
  endfunction

  function automatic bit union_find_step(input req_kind_t kind,
                                         input logic [ELEM_W-1:0] a,
                                         input logic [ELEM_W-1:0] b);
    logic [ELEM_W-1:0] ra;
    logic [ELEM_W-1:0] rb;
    // 10-bit indices never reach NUM_ELEM, so the out-of-range case cannot occur
    ra = find_compress(a);
    rb = find_compress(b);
    if (kind == REQ_UNION && ra != rb) parent_tbl[ra] = rb;
    return ra == rb;
  endfunction

  task automatic offer_request(input req_kind_t kind, input logic [ELEM_W-1:0] a,
                               input logic [ELEM_W-1:0] b, input bit known,
                               input bit known_same);
    logic [S_TDATA_W-1:0] word;
    int                   gap;
    bit                   same;
    if (tx_calm > 0) begin
      tx_calm--;
      gap = 0;
    end else begin
      gap = rand_gap();
      if ($urandom_range(0, 49) == 0) tx_calm = 40;
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word                     = '0;
    word[ELEM_W-1:0]         = a;
    word[2*ELEM_W-1:ELEM_W]  = b;
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    same = union_find_step(kind, a, b);
    same_set_q.push_back(known ? known_same : same);
  endtask

  // Result side: random stalls, calm stretches, and one long hold-off.
  initial begin
    int  stall_left;
    int  rx_calm;
    bit  held;
    bit  exp_same;
    stall_left = 0;
    rx_calm    = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        if (same_set_q.size() == 0) begin
          $display("%0t: unexpected result, same_set=%0b", $time, m_tdata[0]);
          n_err++;
        end else begin
          exp_same = same_set_q.pop_front();
          if (m_tdata[0] !== exp_same) begin
            $display("%0t: same_set mismatch: expected %0b, actual %0b",
                     $time, exp_same, m_tdata[0]);
            n_err++;
          end
        end
        n_results++;
      end
      if (n_results == HOLD_AT && !held) begin
        held       = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (rx_calm > 0) begin
          rx_calm--;
        end else begin
          if ($urandom_range(0, 3) == 0) stall_left = rand_gap();
          if ($urandom_range(0, 99) == 0) rx_calm = 60;
        end
      end
    end
  end

  initial begin
    int                n_rand;
    int                mode;
    int                span;
    int                len;
    int                drain;
    logic [ELEM_W-1:0] base;
    logic [ELEM_W-1:0] stride;
    logic [ELEM_W-1:0] x;
    logic [ELEM_W-1:0] y;
    req_kind_t         kind;
    for (int i = 0; i < NUM_ELEM; i++) parent_tbl[i] = i[ELEM_W-1:0];
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++)
      offer_request(dir_tab[i].kind, dir_tab[i].first[ELEM_W-1:0],
                    dir_tab[i].second[ELEM_W-1:0], dir_tab[i].known,
                    dir_tab[i].known_same);

    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      mode = $urandom_range(0, 9);
      if (mode < 7) begin
        // small neighborhood, so sets merge and queries hit both outcomes
        base = ELEM_W'($urandom_range(0, NUM_ELEM - 1));
        span = $urandom_range(8, 48);
        for (int k = 0; k < 16; k++) begin
          x    = ELEM_W'(base + $urandom_range(0, span - 1));
          y    = ELEM_W'(base + $urandom_range(0, span - 1));
          kind = ($urandom_range(0, 9) < 4) ? REQ_UNION : REQ_QUERY;
          offer_request(kind, x, y, 1'b0, 1'b0);
          n_rand++;
        end
      end else if (mode < 8) begin
        // build a chain, then query its ends to force a long walk and compression
        base   = ELEM_W'($urandom_range(0, NUM_ELEM - 1));
        stride = {(ELEM_W-1)'($urandom_range(0, 511)), 1'b1};
        len    = $urandom_range(6, 30);
        x      = base;
        for (int k = 0; k < len; k++) begin
          y = x + stride;
          offer_request(REQ_UNION, x, y, 1'b0, 1'b0);
          x = y;
          n_rand++;
        end
        offer_request(REQ_QUERY, base, x, 1'b0, 1'b0);
        offer_request(REQ_QUERY, base, x + stride, 1'b0, 1'b0);
        n_rand += 2;
      end else begin
        x    = ELEM_W'($urandom_range(0, NUM_ELEM - 1));
        y    = ELEM_W'($urandom_range(0, NUM_ELEM - 1));
        kind = req_kind_t'($urandom_range(0, 1));
        offer_request(kind, x, y, 1'b0, 1'b0);
        n_rand++;
      end
    end
    s_tvalid <= 1'b0;

    drain = 0;
    while (same_set_q.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (same_set_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, same_set_q.size());
      n_err++;
    end
    if (n_err == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
